### sv/bbd_pkg.sv
`timescale 1ns / 1ps

package bbd_pkg;

  // fixed field widths
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned CHAN_W     = 8;
  localparam int unsigned COORD_W    = 12;
  localparam int unsigned CFG_DATA_W = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned HEIGHT_W   = 13;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_YUV   = 2'd2;

  localparam int unsigned WIDTH_RST  = 1280;
  localparam int unsigned HEIGHT_RST = 960;
  localparam int unsigned DIM_MIN    = 6;
  localparam int unsigned HEIGHT_MAX = 4096;
  localparam int unsigned ROW_MAX    = 4095;

  // Bayer phase {row[0], col[0]}
  localparam logic [1:0] PH_GREEN_B = 2'b00;
  localparam logic [1:0] PH_BLUE    = 2'b01;
  localparam logic [1:0] PH_RED     = 2'b10;
  localparam logic [1:0] PH_GREEN_R = 2'b11;

  // color conversion, computed modulo 2^PROD_W (only bits [23:16] survive)
  localparam int unsigned PROD_W    = 24;
  localparam int unsigned YUV_FRAC  = 16;
  localparam int unsigned YUV_ROUND = 32768;

  typedef logic signed [8:0] coef_t;

  localparam coef_t YUV_COEF [3][3] = '{
    '{ 9'sd66,   9'sd129,  9'sd25  },
    '{ -9'sd38,  -9'sd74,  9'sd112 },
    '{ 9'sd112,  -9'sd94,  -9'sd18 }
  };

  localparam logic [CHAN_W-1:0] YUV_OFFSET [3] = '{ 8'd16, 8'd128, 8'd128 };

endpackage

### sv/bbd_if.sv
`timescale 1ns / 1ps

interface bbd_in_if import bbd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] raw_sample;
  logic                start_of_frame;

  modport source (output valid, raw_sample, start_of_frame, input ready);
  modport sink   (input valid, raw_sample, start_of_frame, output ready);
endinterface

interface bbd_out_if import bbd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CHAN_W-1:0]  red_or_y;
  logic [CHAN_W-1:0]  green_or_u;
  logic [CHAN_W-1:0]  blue_or_v;
  logic [COORD_W-1:0] pixel_column;
  logic [COORD_W-1:0] pixel_row;

  modport source (output valid, red_or_y, green_or_u, blue_or_v, pixel_column, pixel_row,
                  input ready);
  modport sink   (input valid, red_or_y, green_or_u, blue_or_v, pixel_column, pixel_row,
                  output ready);
endinterface

### sv/bayer_bilinear_demosaic_stream_core.sv
`timescale 1ns / 1ps

// Bilinear demosaic for a GBRG Bayer stream.
// in_i carries one raw sample per word in raster order; start_of_frame marks
// column 0 of row 0. out_o carries one RGB or YUV pixel per word with its
// image position; only pixels whose 2x2 quad lies inside the border band
// [2, dim-3) are sent, all other samples produce no word.
// Configuration (width, height, RGB/YUV select) is written through
// cfg_we_i/cfg_idx_i/cfg_data_i; width and height are clamped on write.
// Write it only while the stream is idle; the block does not enforce it.
// Throughput: one sample per clock unless out_o stalls. The two line stores
// are single memories read once and written once per sample, which sets
// that rate. Once the sample that completes its 3x3 neighborhood is taken,
// a pixel word passes the line store read, window sum, scale/multiply and
// output (matrix sum) registers in that order before it is valid on out_o.
// Each stage has its own valid bit, so bubbles collapse: with out_o stalled
// the block keeps taking samples until all four stages hold words, and
// in_i.ready drops only then.
// Reset clears the counters, the window and the pipeline; the line stores
// are not cleared and unwritten entries only ever reach border pixels.
module bayer_bilinear_demosaic_stream_core import bbd_pkg::*; #(
  parameter int unsigned MAX_WIDTH   = 4096,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  bbd_in_if.sink                in_i,
  bbd_out_if.source             out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned AW        = $clog2(MAX_WIDTH);
  localparam int unsigned WW        = $clog2(MAX_WIDTH + 1);
  localparam int unsigned XW        = (WW > CFG_DATA_W) ? WW : CFG_DATA_W;
  localparam int unsigned SB        = SAMPLE_BITS;
  localparam int unsigned SUMW      = SB + 2;
  localparam int unsigned RGB_SHIFT = SB - 8;
  localparam int unsigned W_RST     = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;

  // ---------------- configuration ----------------
  logic [WW-1:0]       width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic                yuv_q;
  logic [XW-1:0]       cfg_wide;
  logic [XW-1:0]       width_clamp;
  logic [HEIGHT_W-1:0] height_clamp;

  assign cfg_wide = XW'(cfg_data_i);

  always_comb begin
    if (cfg_wide < XW'(DIM_MIN)) begin
      width_clamp = XW'(DIM_MIN);
    end else if (cfg_wide > XW'(MAX_WIDTH)) begin
      width_clamp = XW'(MAX_WIDTH);
    end else begin
      width_clamp = cfg_wide;
    end
    if (cfg_data_i < HEIGHT_W'(DIM_MIN)) begin
      height_clamp = HEIGHT_W'(DIM_MIN);
    end else if (cfg_data_i > HEIGHT_W'(HEIGHT_MAX)) begin
      height_clamp = HEIGHT_W'(HEIGHT_MAX);
    end else begin
      height_clamp = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= WW'(W_RST);
      height_q <= HEIGHT_W'(HEIGHT_RST);
      yuv_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IMAGE_WIDTH:  width_q  <= WW'(width_clamp);
        REG_IMAGE_HEIGHT: height_q <= height_clamp;
        REG_OUTPUT_YUV:   yuv_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  logic s1v_q, s2v_q, s3v_q, ov_q;
  logic ld_out, ld3, ld2, ld1;
  logic acc, s1_adv;

  assign ld_out     = !ov_q || out_o.ready;
  assign ld3        = !s3v_q || ld_out;
  assign ld2        = !s2v_q || ld3;
  assign ld1        = !s1v_q || ld2;
  assign in_i.ready = ld1;
  assign acc        = in_i.valid && ld1;
  assign s1_adv     = s1v_q && ld2;

  // ---------------- position counters ----------------
  logic [AW-1:0]      col_cnt_q;
  logic [COORD_W-1:0] row_cnt_q;
  logic [AW-1:0]      col_raw, col_cur;
  logic [COORD_W-1:0] row_cur;
  logic               row_end;

  always_comb begin
    col_raw = in_i.start_of_frame ? '0 : col_cnt_q;
    row_cur = in_i.start_of_frame ? '0 : row_cnt_q;
    col_cur = (WW'(col_raw) >= width_q) ? '0 : col_raw;
    row_end = (WW'(col_cur) + WW'(1)) >= width_q;
  end

  // ---------------- stage 1: line store read ----------------
  logic [SB-1:0]      s1_sample_q;
  logic [AW-1:0]      s1_col_q;
  logic [COORD_W-1:0] s1_row_q;
  logic               byp_q;
  logic [SB-1:0]      byp_up_q, byp_lo_q;
  logic [SB-1:0]      rdu_q, rdl_q;
  logic [SB-1:0]      up_eff, lo_eff;
  logic               byp_hit;

  logic [SB-1:0] mem_up [MAX_WIDTH];
  logic [SB-1:0] mem_lo [MAX_WIDTH];

  // a repeated start of frame can read column 0 while it is being written
  assign byp_hit = s1_adv && (s1_col_q == col_cur);
  assign up_eff  = byp_q ? byp_up_q : rdu_q;
  assign lo_eff  = byp_q ? byp_lo_q : rdl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_cnt_q <= '0;
      row_cnt_q <= '0;
      s1v_q     <= 1'b0;
    end else begin
      if (ld1) begin
        s1v_q <= acc;
      end
      if (acc) begin
        if (row_end) begin
          col_cnt_q <= '0;
          if (row_cur != COORD_W'(ROW_MAX)) begin
            row_cnt_q <= row_cur + COORD_W'(1);
          end else begin
            row_cnt_q <= row_cur;
          end
        end else begin
          col_cnt_q <= col_cur + AW'(1);
          row_cnt_q <= row_cur;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_sample_q <= in_i.raw_sample[SB-1:0];
      s1_col_q    <= col_cur;
      s1_row_q    <= row_cur;
      byp_q       <= byp_hit;
      byp_up_q    <= lo_eff;
      byp_lo_q    <= s1_sample_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem_up[s1_col_q] <= lo_eff;
    end
    if (acc) begin
      rdu_q <= mem_up[col_cur];
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      mem_lo[s1_col_q] <= s1_sample_q;
    end
    if (acc) begin
      rdl_q <= mem_lo[col_cur];
    end
  end

  // ---------------- window and neighbor sums ----------------
  logic [SB-1:0]       win_q [3][3];
  logic [SB-1:0]       nw    [3][3];
  logic [AW-1:0]       cx, ox;
  logic [COORD_W-1:0]  cy, oy;
  logic                emit;
  logic [SUMW-1:0]     sc, sns, swe, sdg;
  logic [SUMW-1:0]     sum_d [3];
  logic [1:0]          lg_d  [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      nw[r][0] = win_q[r][1];
      nw[r][1] = win_q[r][2];
    end
    nw[0][2] = up_eff;
    nw[1][2] = lo_eff;
    nw[2][2] = s1_sample_q;

    cx   = s1_col_q - AW'(1);
    cy   = s1_row_q - COORD_W'(1);
    ox   = {cx[AW-1:1], 1'b0};
    oy   = {cy[COORD_W-1:1], 1'b0};
    emit = (s1_col_q != '0) && (s1_row_q != '0)
        && (ox >= AW'(2)) && (WW'(ox) < width_q - WW'(3))
        && (oy >= COORD_W'(2)) && (HEIGHT_W'(oy) < height_q - HEIGHT_W'(3));

    sc  = SUMW'(nw[1][1]);
    sns = SUMW'(nw[0][1]) + SUMW'(nw[2][1]);
    swe = SUMW'(nw[1][0]) + SUMW'(nw[1][2]);
    sdg = SUMW'(nw[0][0]) + SUMW'(nw[0][2]) + SUMW'(nw[2][0]) + SUMW'(nw[2][2]);

    unique case ({cy[0], cx[0]})
      PH_GREEN_B: begin
        sum_d[0] = sns;       lg_d[0] = 2'd1;
        sum_d[1] = sc;        lg_d[1] = 2'd0;
        sum_d[2] = swe;       lg_d[2] = 2'd1;
      end
      PH_BLUE: begin
        sum_d[0] = sdg;       lg_d[0] = 2'd2;
        sum_d[1] = sns + swe; lg_d[1] = 2'd2;
        sum_d[2] = sc;        lg_d[2] = 2'd0;
      end
      PH_RED: begin
        sum_d[0] = sc;        lg_d[0] = 2'd0;
        sum_d[1] = sns + swe; lg_d[1] = 2'd2;
        sum_d[2] = sdg;       lg_d[2] = 2'd2;
      end
      default: begin
        sum_d[0] = swe;       lg_d[0] = 2'd1;
        sum_d[1] = sc;        lg_d[1] = 2'd0;
        sum_d[2] = sns;       lg_d[2] = 2'd1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '{default: '0};
    end else if (s1_adv) begin
      win_q <= nw;
    end
  end

  // ---------------- stage 2: channel sums ----------------
  logic [SUMW-1:0]    s2_sum_q [3];
  logic [1:0]         s2_lg_q  [3];
  logic [COORD_W-1:0] s2_cx_q, s2_cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2v_q <= 1'b0;
    end else if (ld2) begin
      s2v_q <= s1v_q && emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      s2_sum_q <= sum_d;
      s2_lg_q  <= lg_d;
      s2_cx_q  <= COORD_W'(cx);
      s2_cy_q  <= cy;
    end
  end

  // ---------------- stage 3: scale and matrix products ----------------
  logic [SB-1:0]     full_rgb [3];
  logic [CHAN_W-1:0] rgb8     [3];
  logic [PROD_W-1:0] prod_d   [3][3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      full_rgb[k] = SB'(s2_sum_q[k] >> s2_lg_q[k]);
      rgb8[k]     = CHAN_W'(s2_sum_q[k] >> (s2_lg_q[k] + RGB_SHIFT));
    end
    // two's complement modulo 2^PROD_W is enough for the wrapped 8-bit result
    for (int k = 0; k < 3; k++) begin
      for (int j = 0; j < 3; j++) begin
        prod_d[k][j] = PROD_W'(YUV_COEF[k][j]) * PROD_W'(full_rgb[j]);
      end
    end
  end

  logic [CHAN_W-1:0]  s3_rgb_q  [3];
  logic [PROD_W-1:0]  s3_prod_q [3][3];
  logic [COORD_W-1:0] s3_cx_q, s3_cy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3v_q <= 1'b0;
    end else if (ld3) begin
      s3v_q <= s2v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3 && s2v_q) begin
      s3_rgb_q  <= rgb8;
      s3_prod_q <= prod_d;
      s3_cx_q   <= s2_cx_q;
      s3_cy_q   <= s2_cy_q;
    end
  end

  // ---------------- output register ----------------
  logic [PROD_W-1:0]  ysum  [3];
  logic [CHAN_W-1:0]  chan_d [3];
  logic [CHAN_W-1:0]  out_chan_q [3];
  logic [COORD_W-1:0] out_col_q, out_row_q;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      ysum[k]   = s3_prod_q[k][0] + s3_prod_q[k][1] + s3_prod_q[k][2] + PROD_W'(YUV_ROUND);
      chan_d[k] = yuv_q ? (ysum[k][YUV_FRAC +: CHAN_W] + YUV_OFFSET[k]) : s3_rgb_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ld_out) begin
      ov_q <= s3v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_out && s3v_q) begin
      out_chan_q <= chan_d;
      out_col_q  <= s3_cx_q;
      out_row_q  <= s3_cy_q;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.red_or_y     = out_chan_q[0];
  assign out_o.green_or_u   = out_chan_q[1];
  assign out_o.blue_or_v    = out_chan_q[2];
  assign out_o.pixel_column = out_col_q;
  assign out_o.pixel_row    = out_row_q;

  // ---------------- assertions ----------------
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (s1v_q && s2v_q && s3v_q && ov_q && !out_o.ready))
    else $error("input stalled while a pipeline stage is free");

  a_bypass_col0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1v_q && byp_q) |-> (s1_col_q == '0))
    else $error("line store bypass on a column other than 0");

  a_row_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (out_row_q >= COORD_W'(2)))
    else $error("pixel emitted in the top border");

endmodule

### bench/bayer_bilinear_demosaic_stream_core_tb.sv
`timescale 1ns / 1ps

module bayer_bilinear_demosaic_stream_core_tb;
  import bbd_pkg::*;

  localparam int unsigned MAX_W          = 4096;
  localparam int unsigned DRAIN_CYCLES   = 10;
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RAND_WORDS     = 330;
  localparam int unsigned CALM_WORDS     = 270;

  // BT.601-style integer matrix, rows Y, U, V over R, G, B
  localparam int YUV_MAT [3][3] = '{'{66, 129, 25}, '{-38, -74, 112}, '{112, -94, -18}};
  localparam int YUV_OFS [3]    = '{16, 128, 128};
  localparam int YUV_RND        = 32768;
  localparam int YUV_SHR        = 16;

  typedef enum {FILL_RANDOM, FILL_GREEN_MAX, FILL_GREEN_ZERO} fill_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                sof;
  } raw_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  r_y;
    logic [CHAN_W-1:0]  g_u;
    logic [CHAN_W-1:0]  b_v;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } pixel_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bbd_in_if  in_if ();
  bbd_out_if out_if ();

  bayer_bilinear_demosaic_stream_core #(
    .MAX_WIDTH  (MAX_W),
    .SAMPLE_BITS(SAMPLE_W)
  ) DUT (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_i      (in_if),
    .out_o     (out_if),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  raw_word_t word_q [$];
  pixel_t    pixel_q [$];

  // predictor state
  bit [SAMPLE_W-1:0] line_upper [MAX_W];
  bit [SAMPLE_W-1:0] line_lower [MAX_W];
  bit [SAMPLE_W-1:0] win [3][3];
  int unsigned       pos_col;
  int unsigned       pos_row;
  int unsigned       reg_width  = WIDTH_RST;
  int unsigned       reg_height = HEIGHT_RST;
  bit                reg_yuv;

  bit          idle_on = 1'b1;
  int unsigned errors;
  int unsigned n_raw_words;
  int unsigned n_pix_words;
  int unsigned n_settings;
  int unsigned idle_cycles;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    clamp_dim = (v < DIM_MIN) ? DIM_MIN : ((v > hi) ? hi : v);
  endfunction

  function automatic bit in_band(input int unsigned pos, input int unsigned dim);
    int unsigned origin;
    origin = pos & ~32'd1;
    in_band = (origin >= 2) && (origin < dim - 3);
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample(input fill_e fill, input int col,
                                                      input int row);
    bit green;
    green = ((col ^ row) & 1) == 0;
    case (fill)
      FILL_GREEN_MAX:  pick_sample = green ? 16'hFFFF : 16'h0000;
      FILL_GREEN_ZERO: pick_sample = green ? 16'h0000 : 16'hFFFF;
      default: begin
        if ($urandom_range(0, 3) == 0) pick_sample = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        else pick_sample = 16'($urandom);
      end
    endcase
  endfunction

  // one raw word in, at most one pixel expected out
  task automatic demosaic_predict(input logic [SAMPLE_W-1:0] smp, input logic sof);
    int unsigned w, h, col, row, cx, cy;
    int unsigned ctr, ns, we, dg;
    int unsigned sum [3];
    int unsigned shf [3];
    int unsigned rgb [3];
    logic [CHAN_W-1:0] chan [3];
    logic [1:0] phase;
    longint acc;
    pixel_t px;
    w = clamp_dim(reg_width, MAX_W);
    h = clamp_dim(reg_height, HEIGHT_MAX);
    if (sof) begin
      pos_col = 0;
      pos_row = 0;
    end
    if (pos_col >= w) pos_col = 0;
    col = pos_col;
    row = pos_row;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = line_upper[col];
    win[1][2] = line_lower[col];
    win[2][2] = smp;
    line_upper[col] = line_lower[col];
    line_lower[col] = smp;
    if (col >= 1 && row >= 1 && in_band(col - 1, w) && in_band(row - 1, h)) begin
      cx = col - 1;
      cy = row - 1;
      ctr = win[1][1];
      ns = int'(win[0][1]) + int'(win[2][1]);
      we = int'(win[1][0]) + int'(win[1][2]);
      dg = int'(win[0][0]) + int'(win[0][2]) + int'(win[2][0]) + int'(win[2][2]);
      phase = {cy[0], cx[0]};
      case (phase)
        PH_GREEN_B: begin
          sum = '{ns, ctr, we};
          shf = '{1, 0, 1};
        end
        PH_BLUE: begin
          sum = '{dg, ns + we, ctr};
          shf = '{2, 2, 0};
        end
        PH_RED: begin
          sum = '{ctr, ns + we, dg};
          shf = '{0, 2, 2};
        end
        default: begin
          sum = '{we, ctr, ns};
          shf = '{1, 0, 1};
        end
      endcase
      for (int k = 0; k < 3; k++) begin
        if (reg_yuv) rgb[k] = sum[k] >> shf[k];
        else rgb[k] = (sum[k] >> (shf[k] + SAMPLE_W - 8)) & 32'hFF;
      end
      for (int k = 0; k < 3; k++) begin
        if (reg_yuv) begin
          acc = 0;
          for (int j = 0; j < 3; j++) acc += longint'(YUV_MAT[k][j]) * longint'(rgb[j]);
          chan[k] = CHAN_W'(((acc + longint'(YUV_RND)) >>> YUV_SHR) + YUV_OFS[k]);
        end else begin
          chan[k] = CHAN_W'(rgb[k]);
        end
      end
      px.r_y = chan[0];
      px.g_u = chan[1];
      px.b_v = chan[2];
      px.col = cx[COORD_W-1:0];
      px.row = cy[COORD_W-1:0];
      pixel_q.push_back(px);
    end
    if (col + 1 >= w) begin
      pos_col = 0;
      if (pos_row < ROW_MAX) pos_row++;
    end else begin
      pos_col = col + 1;
    end
  endtask

  task automatic cmp_field(input string name, input logic [COORD_W-1:0] want,
                           input logic [COORD_W-1:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // checked at the falling edge so the driver and monitor updates have settled
  task automatic wait_drained();
    do @(negedge clk_i);
    while (word_q.size() != 0 || in_if.valid || pixel_q.size() != 0);
    // samples that complete no pixel may still be in the pipe
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= CFG_DATA_W'(value);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:  reg_width  = value & 32'h1FFF;
      REG_IMAGE_HEIGHT: reg_height = value & 32'h1FFF;
      REG_OUTPUT_YUV:   reg_yuv    = value[0];
      default: ;
    endcase
  endtask

  task automatic configure(input int unsigned width, input int unsigned height, input bit yuv);
    wait_drained();
    write_reg(REG_IMAGE_WIDTH, width);
    write_reg(REG_IMAGE_HEIGHT, height);
    write_reg(REG_OUTPUT_YUV, yuv);
    n_settings++;
  endtask

  task automatic push_frame(input int n_words, input int w_eff, input fill_e fill,
                            input int hold_at, input bit noisy);
    raw_word_t wd;
    for (int i = 0; i < n_words; i++) begin
      if (i == hold_at) wait_drained();
      wd.sof    = (i == 0) || (noisy && $urandom_range(0, 99) == 0);
      wd.sample = pick_sample(fill, i % w_eff, i / w_eff);
      word_q.push_back(wd);
    end
  endtask

  // driver: feeds raw words, predicts on every accepted one
  always @(posedge clk_i or negedge rst_ni) begin : drive_raw
    raw_word_t   wd;
    int unsigned gap_left;
    if (!rst_ni) begin
      in_if.valid          <= 1'b0;
      in_if.raw_sample     <= '0;
      in_if.start_of_frame <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        demosaic_predict(in_if.raw_sample, in_if.start_of_frame);
        n_raw_words++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (word_q.size() == 0) begin
          in_if.valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 10);
          in_if.valid <= 1'b0;
        end else begin
          wd = word_q.pop_front();
          in_if.valid          <= 1'b1;
          in_if.raw_sample     <= wd.sample;
          in_if.start_of_frame <= wd.sof;
        end
      end
    end
  end

  // monitor: checks pixel words against the oldest prediction
  always @(posedge clk_i or negedge rst_ni) begin : watch_pixels
    pixel_t      want;
    int unsigned stall_left;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_pix_words++;
        if (pixel_q.size() == 0) begin
          errors++;
          $display("%0t ns: unexpected pixel word, expected none, actual col %0d row %0d",
                   $time, out_if.pixel_column, out_if.pixel_row);
        end else begin
          want = pixel_q.pop_front();
          cmp_field("red_or_y", want.r_y, out_if.red_or_y);
          cmp_field("green_or_u", want.g_u, out_if.green_or_u);
          cmp_field("blue_or_v", want.b_v, out_if.blue_or_v);
          cmp_field("pixel_column", want.col, out_if.pixel_column);
          cmp_field("pixel_row", want.row, out_if.pixel_row);
        end
      end
      if (stall_left != 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t ns: watchdog, no word moved for %0d cycles", $time, idle_cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int unsigned w_reg, h_reg, w_eff, h_eff, rows;
    int          n_words, hold_at;
    int unsigned rand_words;
    bit          first;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = REG_IMAGE_WIDTH;
    cfg_data_i           = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // smallest image, green at max and red/blue at zero, all four Bayer phases
    configure(6, 6, 1'b0);
    push_frame(6 * 5, 6, FILL_GREEN_MAX, -1, 1'b0);
    // inverse pattern in YUV, green at zero and red/blue at max; extra rows past the last one
    configure(6, 6, 1'b1);
    push_frame(6 * 7, 6, FILL_GREEN_ZERO, -1, 1'b0);
    // width below range clamps to 6; height at the top of its range
    configure(0, HEIGHT_MAX, 1'b0);
    push_frame(6 * 8, 6, FILL_RANDOM, -1, 1'b0);
    // width above range clamps to the full line store; a short first row emits nothing
    configure(8191, 0, 1'b1);
    push_frame(64, MAX_W, FILL_RANDOM, -1, 1'b0);

    rand_words = 0;
    first = 1'b1;
    while (rand_words < RAND_WORDS) begin
      case ($urandom_range(0, 9))
        0:       w_reg = $urandom_range(0, 5);
        1:       w_reg = $urandom_range(11, 16);
        default: w_reg = $urandom_range(6, 10);
      endcase
      case ($urandom_range(0, 9))
        0:       h_reg = $urandom_range(0, 5);
        1:       h_reg = HEIGHT_MAX;
        2:       h_reg = $urandom_range(HEIGHT_MAX + 1, 8191);
        default: h_reg = $urandom_range(6, 8);
      endcase
      if (rand_words >= CALM_WORDS) idle_on = 1'b0;
      configure(w_reg, h_reg, 1'($urandom_range(0, 1)));
      w_eff = clamp_dim(w_reg, MAX_W);
      h_eff = clamp_dim(h_reg, HEIGHT_MAX);
      repeat ($urandom_range(1, 2)) begin
        rows = ((h_eff < 8) ? h_eff : 8) + $urandom_range(0, 1);
        n_words = w_eff * rows;
        // cut-off frame now and then
        if ($urandom_range(0, 4) == 0) n_words = $urandom_range(1, n_words);
        hold_at = -1;
        if (n_words > 1 && (first || $urandom_range(0, 3) == 0))
          hold_at = $urandom_range(1, n_words - 1);
        first = 1'b0;
        push_frame(n_words, w_eff, FILL_RANDOM, hold_at, $urandom_range(0, 3) == 0);
        rand_words += n_words;
      end
    end

    wait_drained();
    if (pixel_q.size() != 0) begin
      errors++;
      $display("%0t ns: %0d expected pixel words never arrived", $time, pixel_q.size());
    end
    $display("Covered %0d raw words and %0d pixel words over %0d register settings.",
             n_raw_words, n_pix_words, n_settings);
    $display("RGB and YUV, 6-wide to 4096-wide frames, clamped sizes, cut-off frames.");
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
